@@ design/prefixed_integer_parser_top_assert.svh @@
// assertion macros for the prefixed integer parser
`ifndef PREFIXED_INTEGER_PARSER_TOP_ASSERT_SVH
`define PREFIXED_INTEGER_PARSER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define PIP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prefixed integer parser check failed");

// condition holds in the cycle after the antecedent
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prefixed integer parser check failed");

`endif

@@ design/pip_pkg.sv @@
// package with types, character codes and digit decode for the integer parser
package pip_pkg;

  localparam int CH_BITS    = 8;
  localparam int OUT_BITS   = 64;
  localparam int RADIX_BITS = 5;
  localparam int DIGIT_BITS = 6;

  localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_UNDER = 8'h5F;
  localparam logic [CH_BITS-1:0] CH_X     = 8'h78;
  localparam logic [CH_BITS-1:0] CH_D     = 8'h64;
  localparam logic [CH_BITS-1:0] CH_B     = 8'h62;

  localparam logic [RADIX_BITS-1:0] RADIX_2  = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_8  = 5'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_10 = 5'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_16 = 5'd16;

  localparam logic [DIGIT_BITS-1:0] NOT_DIGIT = 6'h3F;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_ZERO   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
    logic [DIGIT_BITS-1:0] d;
    case (c) inside
      [8'h30:8'h39]: d = DIGIT_BITS'(c - 8'h30);
      [8'h41:8'h5A]: d = DIGIT_BITS'(c - 8'h37);
      [8'h61:8'h7A]: d = DIGIT_BITS'(c - 8'h57);
      default:       d = NOT_DIGIT;
    endcase
    return d;
  endfunction

endpackage

@@ design/prefixed_integer_parser_top.sv @@
// prefixed integer parser: one string byte per beat in, one 64-bit value per string out
//
// Takes one ASCII byte per beat on ch and gives one result beat on value for each zero
// byte, which ends a string. A leading 0 picks the radix from the next byte (x hex,
// d decimal, b binary, otherwise octal starting with that byte); otherwise a leading
// minus negates a decimal value. Underscores are skipped and the first byte that is
// no digit of the radix stops parsing until the zero byte. The value wraps modulo
// 2^VALUE_WIDTH and is sign extended to 64 bits. A byte enters an input register, and
// its parser state update (one shift-and-add multiply by the radix plus the digit) is
// registered as it leaves that register; the result lands in an output register. One
// byte per cycle is sustained while the output does not stall. The input register fills
// while a result waits, so one byte is taken even under output stall.
`include "prefixed_integer_parser_top_assert.svh"

module prefixed_integer_parser_top import pip_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CH_BITS-1:0]         ch,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] value
);

  logic                   v1;
  logic [CH_BITS-1:0]     ch1;
  phase_t                 phase, phase_next;
  logic [RADIX_BITS-1:0]  radix, radix_next;
  logic                   negative, negative_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;

  logic                   adv;
  logic                   fire;
  logic                   is_end;
  logic                   take;
  logic [RADIX_BITS-1:0]  radix_eff;
  logic [DIGIT_BITS-1:0]  digit;
  logic [VALUE_WIDTH-1:0] acc_scaled;
  logic [VALUE_WIDTH-1:0] mag;
  logic signed [VALUE_WIDTH-1:0] result;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !v1 || adv;
  assign fire     = v1 && adv;
  assign is_end   = (ch1 == CH_NUL);
  assign digit    = digit_of(ch1);

  always_comb begin
    case (radix_eff)
      RADIX_2:  acc_scaled = acc << 1;
      RADIX_8:  acc_scaled = acc << 3;
      RADIX_16: acc_scaled = acc << 4;
      default:  acc_scaled = (acc << 3) + (acc << 1);
    endcase
  end

  assign mag    = negative ? (~acc + VALUE_WIDTH'(1)) : acc;
  assign result = signed'(mag);

  // next parser state for the byte held in the input register
  always_comb begin
    phase_next    = phase;
    radix_next    = radix;
    negative_next = negative;
    acc_next      = acc;
    take          = 1'b0;
    radix_eff     = radix;
    case (phase)
      PH_START: begin
        radix_eff = RADIX_10;
        if (ch1 == CH_ZERO) begin
          phase_next = PH_ZERO;
        end else if (ch1 == CH_MINUS) begin
          negative_next = 1'b1;
          radix_next    = RADIX_10;
          phase_next    = PH_DIGITS;
        end else begin
          radix_next = RADIX_10;
          phase_next = PH_DIGITS;
          take       = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_next = PH_DIGITS;
        radix_eff  = RADIX_8;
        if (ch1 == CH_X) begin
          radix_next = RADIX_16;
        end else if (ch1 == CH_D) begin
          radix_next = RADIX_10;
        end else if (ch1 == CH_B) begin
          radix_next = RADIX_2;
        end else begin
          radix_next = RADIX_8;
          take       = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
    if (take && ch1 != CH_UNDER) begin
      if (digit >= DIGIT_BITS'(radix_eff)) begin
        phase_next = PH_STOP;
      end else begin
        acc_next = acc_scaled + VALUE_WIDTH'(digit);
      end
    end
    if (is_end) begin
      phase_next    = PH_START;
      radix_next    = RADIX_10;
      negative_next = 1'b0;
      acc_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_START;
      radix     <= RADIX_10;
      negative  <= 1'b0;
      acc       <= '0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (adv) begin
        out_valid <= v1 && is_end;
      end
      if (fire) begin
        phase    <= phase_next;
        radix    <= radix_next;
        negative <= negative_next;
        acc      <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ch1 <= ch;
    end
    if (fire && is_end) begin
      value <= OUT_BITS'(result);
    end
  end

  `PIP_ASSERT_NEXT(a_no_result_mid_string, clk, rst, fire && !is_end, !out_valid)
  `PIP_ASSERT_NEXT(a_clear_after_end, clk, rst, fire && is_end,
    phase == PH_START && acc == '0 && !negative && radix == RADIX_10)
  `PIP_ASSERT_NEXT(a_stop_holds, clk, rst, phase == PH_STOP && !(fire && is_end),
    phase == PH_STOP)
  `PIP_ASSERT_NOW(a_radix_legal, clk, rst, 1'b1,
    radix == RADIX_2 || radix == RADIX_8 || radix == RADIX_10 || radix == RADIX_16)

endmodule
